@@ src/pfba_pkg.sv @@
// Shared types, register indexes, status codes and size constants of the block allocator.
package pfba_pkg;

  localparam int MAX_PAGES_DEF = 16;
  localparam int MAX_OPP_DEF = 64;
  localparam int POINTER_BYTES_DEF = 8;

  localparam int ADDR_W = 24;
  localparam int COUNT_W = 11;
  localparam int PAGES_W = 5;
  localparam int TOTAL_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;
  localparam int OBJ_W = 13;
  localparam int BYTE_W = 8;
  localparam int OPP_CFG_W = 7;
  localparam int MAXP_CFG_W = 5;
  localparam int STRIDE_W = 14;
  localparam int STRIDE_MAX = 8191 + 255 + 2 * 255;

  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECTS_PER_PAGE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAGES = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_PAGES = 2'd1;
  localparam logic [1:0] ST_BAD_BOUNDARY = 2'd2;
  localparam logic [1:0] ST_DOUBLE_FREE = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  block_address;
    logic [TOTAL_W-1:0] alloc_number;
    logic [COUNT_W-1:0] objects_in_use;
    logic [COUNT_W-1:0] free_objects;
    logic [PAGES_W-1:0] pages_in_use;
    logic [COUNT_W-1:0] peak_in_use;
    logic [TOTAL_W-1:0] total_allocations;
    logic [TOTAL_W-1:0] total_frees;
  } out_word_t;

endpackage

@@ src/pfba_stream.sv @@
// Valid/ready channel that carries one word of a given type.
interface pfba_stream #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ src/paged_fixed_block_allocator.sv @@
// Top level of the paged fixed-size block allocator with a freed-block stack.
//
// Requests arrive as words on in_ch: func selects allocate or free, address names the
// object to free. Each request yields exactly one word on out_ch with a status, the
// handed-out address and allocation number, and a snapshot of the pool counters.
// Configuration registers (cfg_we/cfg_index/cfg_data): write only while idle; the block does not enforce it.
//
// A small sequencer drives one shared multiplier and one restoring divider. A free runs
// the divider twice, 24 steps each (address by page size, then offset by block stride);
// the divider sets the rate for frees.
//
// After reset the block clears its in-use bit memory, one entry a cycle, over all
// 2**(page bits + index bits) entries (1024 with the default sizes); in_ch is not ready
// during that pass. Page 0 is open after reset.
//
// The result sits in an output register. A new request is accepted while a result
// still waits; if the receiver stalls, the next result waits in its final state until
// the output register frees up.
module paged_fixed_block_allocator #(
  parameter int MAX_PAGES = pfba_pkg::MAX_PAGES_DEF,
  parameter int MAX_OBJECTS_PER_PAGE = pfba_pkg::MAX_OPP_DEF,
  parameter int POINTER_BYTES = pfba_pkg::POINTER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pfba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfba_pkg::CFG_DATA_W-1:0]  cfg_data,
  pfba_stream.sink                         in_ch,
  pfba_stream.source                       out_ch
);

  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int IW = (MAX_OBJECTS_PER_PAGE > 1) ? $clog2(MAX_OBJECTS_PER_PAGE) : 1;
  localparam int IDW = PW + IW;
  localparam int DEPTH = 1 << IDW;
  localparam int SLOTS = MAX_PAGES * MAX_OBJECTS_PER_PAGE;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PCW = $clog2(MAX_PAGES + 1);
  localparam int OPPW = $clog2(MAX_OBJECTS_PER_PAGE + 1);
  localparam int MYW = (OPPW > PW) ? OPPW : PW;
  localparam int PGW = $clog2(POINTER_BYTES + MAX_OBJECTS_PER_PAGE * pfba_pkg::STRIDE_MAX + 1);
  localparam int RW = PGW + 1;
  localparam int FW = $clog2(POINTER_BYTES + 511 + 1);
  localparam int AW = pfba_pkg::ADDR_W;
  localparam int ACW = PGW + MYW + 1;
  localparam int DCW = $clog2(AW);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PAGE  = 4'd2;
  localparam logic [3:0] S_APICK = 4'd3;
  localparam logic [3:0] S_ASTK  = 4'd4;
  localparam logic [3:0] S_AWAIT = 4'd5;
  localparam logic [3:0] S_AUPD  = 4'd6;
  localparam logic [3:0] S_AADR  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_FCHK1 = 4'd9;
  localparam logic [3:0] S_FCHK2 = 4'd10;
  localparam logic [3:0] S_FWAIT = 4'd11;
  localparam logic [3:0] S_FUPD  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  // Configuration registers.
  logic [pfba_pkg::OBJ_W-1:0]      object_size;
  logic [pfba_pkg::BYTE_W-1:0]     pad_bytes;
  logic [pfba_pkg::BYTE_W-1:0]     header_bytes;
  logic                            header_mode;
  logic [pfba_pkg::OPP_CFG_W-1:0]  objects_per_page;
  logic [pfba_pkg::MAXP_CFG_W-1:0] max_pages;

  always_ff @(posedge clk) begin
    if (rst) begin
      object_size <= pfba_pkg::OBJ_W'(8);
      pad_bytes <= '0;
      header_bytes <= '0;
      header_mode <= 1'b0;
      objects_per_page <= pfba_pkg::OPP_CFG_W'(4);
      max_pages <= pfba_pkg::MAXP_CFG_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfba_pkg::REG_OBJECT_SIZE: object_size <= cfg_data;
        pfba_pkg::REG_PAD_BYTES: pad_bytes <= cfg_data[pfba_pkg::BYTE_W-1:0];
        pfba_pkg::REG_HEADER_BYTES: header_bytes <= cfg_data[pfba_pkg::BYTE_W-1:0];
        pfba_pkg::REG_HEADER_MODE: header_mode <= cfg_data[0];
        pfba_pkg::REG_OBJECTS_PER_PAGE: objects_per_page <= cfg_data[pfba_pkg::OPP_CFG_W-1:0];
        pfba_pkg::REG_MAX_PAGES: max_pages <= cfg_data[pfba_pkg::MAXP_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Values derived from configuration. Objects per page is clamped to 1..maximum,
  // and a zero object size counts as one byte.
  logic [OPPW-1:0]               opp;
  logic [PCW-1:0]                max_open;
  logic [pfba_pkg::STRIDE_W-1:0] stride;
  logic [FW-1:0]                 first;

  always_comb begin
    if (objects_per_page == '0) begin
      opp = OPPW'(1);
    end else if (32'(objects_per_page) > 32'(MAX_OBJECTS_PER_PAGE)) begin
      opp = OPPW'(MAX_OBJECTS_PER_PAGE);
    end else begin
      opp = OPPW'(objects_per_page);
    end
    if (32'(max_pages) > 32'(MAX_PAGES)) begin
      max_open = PCW'(MAX_PAGES);
    end else begin
      max_open = PCW'(max_pages);
    end
    stride = ((object_size == '0) ? pfba_pkg::STRIDE_W'(1) : pfba_pkg::STRIDE_W'(object_size))
           + pfba_pkg::STRIDE_W'(header_bytes) + pfba_pkg::STRIDE_W'({pad_bytes, 1'b0});
    first = FW'(POINTER_BYTES) + FW'(header_bytes) + FW'(pad_bytes);
  end

  // Pool state.
  logic [3:0]                   state;
  logic [CW-1:0]                stack_depth;
  logic [OPPW-1:0]              fresh_taken;
  logic [PCW-1:0]               pages_open;
  logic [CW-1:0]                live_count;
  logic [CW-1:0]                peak_count;
  logic [pfba_pkg::TOTAL_W-1:0] alloc_total;
  logic [pfba_pkg::TOTAL_W-1:0] free_total;

  // Item working registers.
  logic                         func;
  logic [AW-1:0]                address;
  logic [1:0]                   status;
  logic [AW-1:0]                baddr;
  logic [pfba_pkg::TOTAL_W-1:0] anum;
  logic [IDW-1:0]               id;
  logic [PGW-1:0]               page_bytes;
  logic [ACW-1:0]               acc;
  logic [PW-1:0]                free_page;
  logic [IDW-1:0]               clr_idx;

  // Shared restoring divider: one quotient bit per cycle.
  logic [AW-1:0]  dvd;
  logic [RW-1:0]  rem;
  logic [PGW-1:0] divisor;
  logic [DCW-1:0] div_cnt;
  logic           div_pass;
  logic [RW-1:0]  trial;
  logic           trial_ge;

  assign trial = {rem[PGW-1:0], dvd[AW-1]};
  assign trial_ge = (trial >= RW'(divisor));

  // Shared multiplier.
  logic [PGW-1:0]     mul_x;
  logic [MYW-1:0]     mul_y;
  logic [PGW+MYW-1:0] mul_p;

  always_comb begin
    mul_x = PGW'(stride);
    mul_y = MYW'(opp);
    unique case (state)
      S_AUPD: begin
        mul_x = page_bytes;
        mul_y = MYW'(id[IDW-1:IW]);
      end
      S_AADR: begin
        mul_x = PGW'(stride);
        mul_y = MYW'(id[IW-1:0]);
      end
      default: ;
    endcase
  end

  assign mul_p = (PGW+MYW)'(mul_x) * (PGW+MYW)'(mul_y);

  // Fresh-block selection for an allocate with an empty freed stack.
  logic          need_page;
  logic          pool_full;
  logic [PW-1:0] fresh_page;
  logic [OPPW-1:0] fresh_base;
  logic [IW-1:0] fresh_idx;

  always_comb begin
    need_page = (fresh_taken >= opp);
    pool_full = (pages_open >= max_open) || (32'(pages_open) >= 32'(MAX_PAGES));
    fresh_page = need_page ? PW'(pages_open) : PW'(pages_open - PCW'(1));
    fresh_base = need_page ? '0 : fresh_taken;
    fresh_idx = IW'(opp - OPPW'(1) - fresh_base);
  end

  // Freed-block stack and in-use bits, both registered-read memories.
  logic [IDW-1:0] freed_stack [DEPTH];
  logic           in_use_bits [DEPTH];
  logic [IDW-1:0] stack_q;
  logic           in_use_q;
  logic           stk_we;
  logic [IDW-1:0] stk_raddr;
  logic           iu_we;
  logic [IDW-1:0] iu_waddr;
  logic           iu_wdata;

  always_comb begin
    stk_we = (state == S_FUPD) && in_use_q && (32'(stack_depth) < 32'(SLOTS));
    stk_raddr = IDW'(stack_depth - CW'(1));
    iu_we = 1'b0;
    iu_waddr = id;
    iu_wdata = 1'b0;
    if (state == S_CLR) begin
      iu_we = 1'b1;
      iu_waddr = clr_idx;
    end else if (state == S_AUPD) begin
      iu_we = !in_use_q;
      iu_wdata = 1'b1;
    end else if (stk_we) begin
      iu_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      freed_stack[IDW'(stack_depth)] <= id;
    end
    stack_q <= freed_stack[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (iu_we) begin
      in_use_bits[iu_waddr] <= iu_wdata;
    end
    in_use_q <= in_use_bits[id];
  end

  // Output register.
  logic      out_valid;
  pfba_pkg::out_word_t out_word;
  logic [CW-1:0]   fresh_left;
  logic [CW-1:0]   live_next;

  assign fresh_left = (opp > fresh_taken) ? CW'(opp - fresh_taken) : '0;
  assign live_next = live_count + CW'(!in_use_q);

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      stack_depth <= '0;
      fresh_taken <= '0;
      pages_open <= PCW'(1);
      live_count <= '0;
      peak_count <= '0;
      alloc_total <= '0;
      free_total <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output register loads a new word when it is empty or being read.
      if ((state == S_OUT) && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + IDW'(1);
          if (clr_idx == IDW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            func <= in_ch.data.func;
            address <= in_ch.data.address;
            status <= pfba_pkg::ST_OK;
            baddr <= '0;
            anum <= '0;
            state <= S_PAGE;
          end
        end
        S_PAGE: begin
          page_bytes <= PGW'(POINTER_BYTES) + PGW'(mul_p);
          if (func == pfba_pkg::FUNC_ALLOC) begin
            state <= S_APICK;
          end else begin
            dvd <= address;
            rem <= '0;
            divisor <= PGW'(POINTER_BYTES) + PGW'(mul_p);
            div_cnt <= DCW'(AW - 1);
            div_pass <= 1'b0;
            state <= S_DIV;
          end
        end
        S_APICK: begin
          if (stack_depth != '0) begin
            stack_depth <= stack_depth - CW'(1);
            state <= S_ASTK;
          end else if (need_page && pool_full) begin
            status <= pfba_pkg::ST_NO_PAGES;
            state <= S_OUT;
          end else begin
            if (need_page) begin
              pages_open <= pages_open + PCW'(1);
              fresh_taken <= OPPW'(1);
            end else begin
              fresh_taken <= fresh_taken + OPPW'(1);
            end
            id <= {fresh_page, fresh_idx};
            state <= S_AWAIT;
          end
        end
        S_ASTK: begin
          id <= stack_q;
          state <= S_AWAIT;
        end
        S_AWAIT: begin
          state <= func ? S_FUPD : S_AUPD;
        end
        S_AUPD: begin
          // A block handed out while already marked in use is not counted twice.
          live_count <= live_next;
          if (live_next > peak_count) begin
            peak_count <= live_next;
          end
          if (alloc_total != '1) begin
            alloc_total <= alloc_total + 32'd1;
            anum <= header_mode ? alloc_total + 32'd1 : '0;
          end else begin
            anum <= header_mode ? alloc_total : '0;
          end
          acc <= ACW'(mul_p);
          state <= S_AADR;
        end
        S_AADR: begin
          baddr <= AW'(acc + ACW'(first) + ACW'(mul_p));
          state <= S_OUT;
        end
        S_DIV: begin
          dvd <= {dvd[AW-2:0], trial_ge};
          rem <= trial_ge ? (trial - RW'(divisor)) : trial;
          div_cnt <= div_cnt - DCW'(1);
          if (div_cnt == '0) begin
            state <= div_pass ? S_FCHK2 : S_FCHK1;
          end
        end
        S_FCHK1: begin
          // dvd holds the page number, rem the offset within the page.
          if ((dvd < AW'(pages_open)) && (rem >= RW'(first))) begin
            free_page <= PW'(dvd);
            dvd <= AW'(rem - RW'(first));
            rem <= '0;
            divisor <= PGW'(stride);
            div_cnt <= DCW'(AW - 1);
            div_pass <= 1'b1;
            state <= S_DIV;
          end else begin
            status <= pfba_pkg::ST_BAD_BOUNDARY;
            state <= S_OUT;
          end
        end
        S_FCHK2: begin
          if ((rem == '0) && (dvd < AW'(opp))) begin
            id <= {free_page, IW'(dvd)};
            state <= S_AWAIT;
          end else begin
            status <= pfba_pkg::ST_BAD_BOUNDARY;
            state <= S_OUT;
          end
        end
        S_FUPD: begin
          if (!in_use_q) begin
            status <= pfba_pkg::ST_DOUBLE_FREE;
          end else if (stk_we) begin
            stack_depth <= stack_depth + CW'(1);
            if (live_count != '0) begin
              live_count <= live_count - CW'(1);
            end
            if (free_total != '1) begin
              free_total <= free_total + 32'd1;
            end
          end else begin
            status <= pfba_pkg::ST_BAD_BOUNDARY;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || out_ch.ready)) begin
      out_word.status <= status;
      out_word.block_address <= baddr;
      out_word.alloc_number <= anum;
      out_word.objects_in_use <= pfba_pkg::COUNT_W'(live_count);
      out_word.free_objects <= pfba_pkg::COUNT_W'(stack_depth + fresh_left);
      out_word.pages_in_use <= pfba_pkg::PAGES_W'(pages_open);
      out_word.peak_in_use <= pfba_pkg::COUNT_W'(peak_count);
      out_word.total_allocations <= alloc_total;
      out_word.total_frees <= free_total;
    end
  end

endmodule

@@ src/pfba_checker.sv @@
// Port-level assertions for the block allocator, bound to the top level.
module pfba_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [1:0]                       status,
  input logic [pfba_pkg::ADDR_W-1:0]      block_address,
  input logic [pfba_pkg::TOTAL_W-1:0]     alloc_number,
  input logic [pfba_pkg::COUNT_W-1:0]     objects_in_use,
  input logic [pfba_pkg::COUNT_W-1:0]     peak_in_use
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_clear_pass: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready)
    else $error("request accepted during the clearing pass");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != pfba_pkg::ST_OK |-> block_address == '0 && alloc_number == '0)
    else $error("failed request carries an address or number");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> objects_in_use <= peak_in_use)
    else $error("blocks in use exceed the peak");

endmodule

bind paged_fixed_block_allocator pfba_checker u_pfba_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .status(out_ch.data.status),
  .block_address(out_ch.data.block_address),
  .alloc_number(out_ch.data.alloc_number),
  .objects_in_use(out_ch.data.objects_in_use),
  .peak_in_use(out_ch.data.peak_in_use)
);
